@@ rtl/tsad_pkg.sv @@
// tsad_pkg: shared types and constants for the transport stream audio demux
// no dependencies
package tsad_pkg;
    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [7:0] ST_MP3    = 8'h04;
    localparam logic [7:0] ST_AAC_A  = 8'h0F;
    localparam logic [7:0] ST_AAC_B  = 8'h11;
    localparam logic [8:0] PES_PENDING = 9'd511;

    typedef enum logic [1:0] {
        KIND_IGNORE = 2'd0,
        KIND_PAT    = 2'd1,
        KIND_PMT    = 2'd2,
        KIND_AUDIO  = 2'd3
    } t_kind;

    // one result word
    typedef struct packed {
        logic [7:0] audio_byte;
        logic       format_mp3;
        logic       run_last;
    } t_word;

    // results caused by one input byte
    typedef struct packed {
        logic [1:0] count;
        t_word [2:0] words;
    } t_burst;
endpackage

@@ rtl/tsad_if.sv @@
// tsad_if: valid/ready channel carrying the payload of one word
// depends on nothing; payload width set by parameter
interface tsad_if #(parameter int W = 8) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tsad_parse.sv @@
// tsad_parse: per-byte packet parser producing up to three result words
// depends on tsad_pkg
module tsad_parse
    import tsad_pkg::*;
#(
    parameter int PID_SLOTS = 4,
    parameter int PACKET_BYTES = 188
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_burst     o_burst
);
    localparam int CW = $clog2(PID_SLOTS + 1);
    localparam int IW = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;
    localparam logic [7:0] LAST_POS = 8'(PACKET_BYTES - 1);

    logic [7:0]  r_pos, n_pos;
    logic        r_inpk, n_inpk;
    logic [12:0] r_pid, n_pid;
    logic        r_us, n_us, r_ap, n_ap;
    logic [7:0]  r_al, n_al;
    t_kind       r_kind, n_kind;
    logic [12:0] r_pmt [PID_SLOTS];
    logic [12:0] r_aud [PID_SLOTS];
    logic [CW-1:0] r_pmtc, n_pmtc, r_audc, n_audc;
    logic        r_mp3, n_mp3;
    logic [11:0] r_sl, n_sl, r_pil, n_pil;
    logic [7:0]  r_cur, n_cur;
    logic [23:0] r_eb, n_eb;
    logic [7:0]  r_la0, n_la0, r_la1, n_la1;
    logic [8:0]  r_pds, n_pds;
    logic        pmt_we, aud_we;
    logic [12:0] pmt_wd, aud_wd;

    // table lookups
    logic in_aud, in_pmt;
    always_comb begin
        logic [12:0] pid;
        pid = {r_pid[12:8], i_byte};
        in_aud = 1'b0;
        in_pmt = 1'b0;
        for (int i = 0; i < PID_SLOTS; i++) begin
            if (CW'(i) < r_audc && r_aud[i] == pid) in_aud = 1'b1;
            if (CW'(i) < r_pmtc && r_pmt[i] == pid) in_pmt = 1'b1;
        end
    end

    // next state and results
    always_comb begin
        logic [7:0]  base, rel, d, p, arel;
        logic [8:0]  nx;
        logic [12:0] es, pid;
        logic [1:0]  cls;
        logic [1:0]  cnt;
        logic        last;
        logic [7:0]  ob [3];
        logic        mp3_out;
        n_pos = r_pos; n_inpk = r_inpk; n_pid = r_pid; n_us = r_us; n_ap = r_ap;
        n_al = r_al; n_kind = r_kind; n_pmtc = r_pmtc; n_audc = r_audc;
        n_mp3 = r_mp3; n_sl = r_sl; n_pil = r_pil; n_cur = r_cur; n_eb = r_eb;
        n_la0 = r_la0; n_la1 = r_la1; n_pds = r_pds;
        pmt_we = 1'b0; aud_we = 1'b0; pmt_wd = '0; aud_wd = '0;
        cnt = 2'd0; ob[0] = '0; ob[1] = '0; ob[2] = '0;
        base = r_us ? 8'd5 : 8'd4;
        rel = r_pos - base;
        d = rel - r_cur;
        es = '0; cls = '0; nx = '0; pid = '0;
        p = r_ap ? 8'(9'd5 + {1'b0, r_al}) : 8'd4;
        if (r_ap && r_al > 8'd250) p = 8'd255;
        arel = r_pos - p;
        last = (r_pos == LAST_POS);
        if (!r_inpk) begin
            if (i_byte == SYNC_BYTE) begin
                n_inpk = 1'b1; n_pos = 8'd1;
                n_pid = '0; n_us = 1'b0; n_ap = 1'b0; n_al = '0; n_kind = KIND_IGNORE;
                n_sl = '0; n_pil = '0; n_cur = '0; n_eb = '0; n_la0 = '0; n_la1 = '0;
                n_pds = '0;
            end
        end else begin
            if (r_pos == 8'd1) begin
                n_pid = {i_byte[4:0], 8'h00};
                n_us = i_byte[6];
            end else if (r_pos == 8'd2) begin
                pid = {r_pid[12:8], i_byte};
                n_pid = pid;
                if (pid == '0) n_kind = KIND_PAT;
                else if (r_audc != '0) n_kind = in_aud ? KIND_AUDIO : KIND_IGNORE;
                else if (in_pmt) n_kind = KIND_PMT;
                else n_kind = KIND_IGNORE;
            end else if (r_pos == 8'd3) begin
                n_ap = i_byte[5];
            end
            if (r_pos == 8'd4 && r_ap) n_al = i_byte;
            if (r_pos >= 8'd4) begin
                if (r_kind == KIND_PAT && r_pos >= base) begin
                    // pat section
                    if (rel == 8'd1) n_sl = {i_byte[3:0], 8'h00};
                    else if (rel == 8'd2) begin
                        n_sl = {r_sl[11:8], i_byte}; n_pmtc = '0;
                    end else if (rel >= 8'd8) begin
                        if (rel[1:0] != 2'd3) n_eb = {r_eb[15:0], i_byte};
                        else if ({4'd0, rel} + 12'd2 <= r_sl
                                 && r_pmtc < CW'(PID_SLOTS)) begin
                            pmt_we = 1'b1; pmt_wd = {r_eb[4:0], i_byte};
                            n_pmtc = r_pmtc + 1'b1;
                        end
                    end
                end else if (r_kind == KIND_PMT && r_pos >= base) begin
                    // pmt section
                    if (rel == 8'd1) n_sl = {i_byte[3:0], 8'h00};
                    else if (rel == 8'd2) n_sl = {r_sl[11:8], i_byte};
                    else if (rel == 8'd10) n_pil = {i_byte[3:0], 8'h00};
                    else if (rel == 8'd11) begin
                        nx = 9'd12 + {1'b0, i_byte};
                        n_pil = {r_pil[11:8], i_byte};
                        n_cur = (r_pil[11:8] != 4'd0 || nx > 9'd255) ? 8'd255 : nx[7:0];
                    end else if (rel >= 8'd12 && r_cur != 8'd255 && rel >= r_cur) begin
                        if (d == 8'd0) begin
                            if (!({4'd0, r_cur} + 12'd1 < r_sl)) n_cur = 8'd255;
                            else begin
                                cls = (i_byte == ST_MP3) ? 2'd1 :
                                      ((i_byte == ST_AAC_A || i_byte == ST_AAC_B)
                                       ? 2'd2 : 2'd0);
                                n_eb = {6'd0, cls, 16'd0};
                            end
                        end else if (d == 8'd1) n_eb[12:8] = i_byte[4:0];
                        else if (d == 8'd2) n_eb[7:0] = i_byte;
                        else if (d == 8'd3) n_eb[23:20] = i_byte[3:0];
                        else begin
                            es = {1'b0, r_eb[23:20], i_byte};
                            cls = r_eb[17:16];
                            if (cls == 2'd1 || cls == 2'd2) begin
                                n_mp3 = (cls == 2'd1);
                                if (r_audc < CW'(PID_SLOTS)) begin
                                    aud_we = 1'b1; aud_wd = r_eb[12:0];
                                    n_audc = r_audc + 1'b1;
                                end
                            end
                            n_cur = ({5'd0, r_cur} + 13'd5 + es > 13'd255) ? 8'd255 :
                                    8'(r_cur + 8'd5 + es[7:0]);
                        end
                    end
                end else if (r_kind == KIND_AUDIO && !(r_pos == 8'd4 && r_ap)
                             && r_pos >= p && p != 8'd255) begin
                    // audio payload
                    if (arel == 8'd0) begin
                        n_la0 = i_byte;
                        if (last) begin cnt = 2'd1; ob[0] = i_byte; end
                    end else if (arel == 8'd1) begin
                        n_la1 = i_byte;
                        if (last) begin cnt = 2'd2; ob[0] = r_la0; ob[1] = i_byte; end
                    end else if (arel == 8'd2) begin
                        if (r_la0 == 8'd0 && r_la1 == 8'd0 && i_byte == 8'd1)
                            n_pds = PES_PENDING;
                        else begin
                            cnt = 2'd3; ob[0] = r_la0; ob[1] = r_la1; ob[2] = i_byte;
                            n_pds = {1'b0, p};
                        end
                    end else if (arel == 8'd8 && r_pds == PES_PENDING) begin
                        nx = 9'(10'({2'd0, p}) + 10'd9 + 10'({2'd0, i_byte}) > 10'd511 ? 511 :
                             {2'd0, p} + 10'd9 + {2'd0, i_byte});
                        n_pds = nx;
                    end else if ({1'b0, r_pos} >= r_pds) begin
                        cnt = 2'd1; ob[0] = i_byte;
                    end
                end
            end
            if (r_pos >= LAST_POS) begin n_inpk = 1'b0; n_pos = '0; end
            else n_pos = r_pos + 8'd1;
        end
        mp3_out = r_mp3;
        o_burst.count = cnt;
        for (int k = 0; k < 3; k++) begin
            o_burst.words[k].audio_byte = ob[k];
            o_burst.words[k].format_mp3 = mp3_out;
            o_burst.words[k].run_last = (2'(k + 1) == cnt);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_inpk <= 1'b0; r_pid <= '0; r_us <= 1'b0; r_ap <= 1'b0;
            r_al <= '0; r_kind <= KIND_IGNORE; r_pmtc <= '0; r_audc <= '0;
            r_mp3 <= 1'b0; r_sl <= '0; r_pil <= '0; r_cur <= '0; r_eb <= '0;
            r_la0 <= '0; r_la1 <= '0; r_pds <= '0;
        end else if (i_en) begin
            r_pos <= n_pos; r_inpk <= n_inpk; r_pid <= n_pid; r_us <= n_us;
            r_ap <= n_ap; r_al <= n_al; r_kind <= n_kind; r_pmtc <= n_pmtc;
            r_audc <= n_audc; r_mp3 <= n_mp3; r_sl <= n_sl; r_pil <= n_pil;
            r_cur <= n_cur; r_eb <= n_eb; r_la0 <= n_la0; r_la1 <= n_la1;
            r_pds <= n_pds;
        end
    end

    // pid tables
    always_ff @(posedge i_clk) begin
        if (i_en && pmt_we) r_pmt[r_pmtc[IW-1:0]] <= pmt_wd;
        if (i_en && aud_we) r_aud[r_audc[IW-1:0]] <= aud_wd;
    end

    // table counts and packet position stay in range
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pmtc <= CW'(PID_SLOTS) && r_audc <= CW'(PID_SLOTS))
        else $error("pid table count overflow");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("packet position past packet end");
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inpk |-> r_pos == 8'd0)
        else $error("position set outside a packet");
endmodule

@@ rtl/tsad_outq.sv @@
// tsad_outq: holds a burst of up to three words and serializes them
// depends on tsad_pkg
module tsad_outq
    import tsad_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_burst i_burst,
    output logic   o_free,
    output logic   o_valid,
    output t_word  o_word,
    input  logic   i_ready
);
    logic [1:0]  r_cnt, r_idx;
    t_word [2:0] r_words;
    logic        pop_last;

    assign o_valid = (r_cnt != 2'd0);
    assign o_word = r_words[r_idx];
    assign pop_last = o_valid && i_ready && (r_idx + 2'd1 == r_cnt);
    assign o_free = !o_valid || pop_last;

    // burst register with read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_idx <= '0;
        end else if (i_load && o_free) begin
            r_cnt <= i_burst.count; r_idx <= '0;
        end else if (pop_last) begin
            r_cnt <= '0; r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) r_words <= i_burst.words;
    end

    // read index stays inside the held burst
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_idx < r_cnt)
        else $error("read index past burst");
endmodule

@@ rtl/ts_audio_demux_unit.sv @@
// ts_audio_demux_unit: transport stream audio demux top level
// first word of a burst: shown in the cycle after its byte is accepted
// throughput: one byte per cycle while bursts are single and o_out is ready;
// a longer burst holds input while the output queue drains it
// reset: synchronous active low, clears parser state and pid table counts
// depends on tsad_pkg, tsad_if, tsad_parse, tsad_outq
module ts_audio_demux_unit
    import tsad_pkg::*;
#(
    parameter int PID_SLOTS = 4,
    parameter int PACKET_BYTES = 188
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tsad_if.sink   i_in,
    tsad_if.source o_out
);
    t_burst burst;
    t_word  word;
    logic   free, acc;

    assign i_in.ready = free;
    assign acc = i_in.valid && free;

    tsad_parse #(.PID_SLOTS(PID_SLOTS), .PACKET_BYTES(PACKET_BYTES)) u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(acc), .i_byte(i_in.data[7:0]),
        .o_burst(burst));

    tsad_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(acc), .i_burst(burst),
        .o_free(free), .o_valid(o_out.valid), .o_word(word), .i_ready(o_out.ready));

    assign o_out.data = {word.audio_byte, word.format_mp3, word.run_last};

    // a waiting word holds still, input stalls only behind a waiting word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("output word changed while waiting");
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with empty output");
endmodule

@@ sim/tsad_checker.sv @@
`timescale 1ns / 1ps
// tsad_checker: watches both channels of the audio demux, predicts each burst
// of audio words and compares the words as they come out
// depends on tsad_pkg
module tsad_checker
    import tsad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_word      i_out_data,
    output int         o_errors,
    output int         o_pending
);
    localparam int PKT_LEN = 188;
    localparam int SLOTS   = 4;

    // parser copy
    int          pkt_pos;
    bit          in_pkt;
    logic [12:0] pid;
    bit          ustart;
    bit          adapt;
    int          alen;
    t_kind       kind;
    logic [12:0] pmt_tab [SLOTS];
    int          pmt_n;
    logic [12:0] aud_tab [SLOTS];
    int          aud_n;
    bit          is_mp3;
    int          sec_len;
    int          pinfo_len;
    int          cursor;
    logic [23:0] pat_shift;
    int          e_cls;
    int          e_pid;
    int          e_eshi;
    logic [7:0]  look0;
    logic [7:0]  look1;
    int          pes_start;

    t_word burst [$];
    t_word audio_expect [$];

    function automatic void put_word(logic [7:0] v);
        t_word w;
        w.audio_byte = v;
        w.format_mp3 = is_mp3;
        w.run_last   = 1'b0;
        if (burst.size() < 3) burst.push_back(w);
    endfunction

    function automatic bit pid_listed(bit audio_side, logic [12:0] p);
        for (int i = 0; i < SLOTS; i++) begin
            if (audio_side && i < aud_n && aud_tab[i] == p) return 1;
            if (!audio_side && i < pmt_n && pmt_tab[i] == p) return 1;
        end
        return 0;
    endfunction

    function automatic void clear_pkt();
        pid = '0; ustart = 0; adapt = 0; alen = 0; kind = KIND_IGNORE;
        sec_len = 0; pinfo_len = 0; cursor = 0; pat_shift = '0;
        e_cls = 0; e_pid = 0; e_eshi = 0; look0 = '0; look1 = '0; pes_start = 0;
    endfunction

    // program association: fills the pmt pid list
    function automatic void pat_in(int rel, logic [7:0] b);
        if (rel == 1) begin
            sec_len = int'(b[3:0]) << 8;
        end else if (rel == 2) begin
            sec_len |= int'(b);
            pmt_n = 0;
        end else if (rel >= 8) begin
            if (((rel - 8) & 3) != 3) begin
                pat_shift = {pat_shift[15:0], b};
            end else if ((rel - 3) + 5 <= sec_len && pmt_n < SLOTS) begin
                pmt_tab[pmt_n] = {pat_shift[4:0], b};
                pmt_n++;
            end
        end
    endfunction

    // program map: appends audio pids
    function automatic void pmt_in(int rel, logic [7:0] b);
        int d;
        int es;
        int nxt;
        if (rel == 1) begin
            sec_len = int'(b[3:0]) << 8;
            return;
        end
        if (rel == 2) begin
            sec_len |= int'(b);
            return;
        end
        if (rel == 10) begin
            pinfo_len = int'(b[3:0]) << 8;
            return;
        end
        if (rel == 11) begin
            pinfo_len |= int'(b);
            nxt = 12 + pinfo_len;
            cursor = nxt > 255 ? 255 : nxt;
            return;
        end
        if (rel < 12 || cursor >= 255 || rel < cursor) return;
        d = rel - cursor;
        if (d == 0) begin
            if (!(cursor + 1 < sec_len)) begin
                cursor = 255;
                return;
            end
            e_cls = (b == ST_MP3) ? 1 : ((b == ST_AAC_A || b == ST_AAC_B) ? 2 : 0);
            e_pid = 0;
            e_eshi = 0;
        end else if (d == 1) begin
            e_pid = int'(b[4:0]) << 8;
        end else if (d == 2) begin
            e_pid |= int'(b);
        end else if (d == 3) begin
            e_eshi = int'(b[3:0]);
        end else begin
            es = (e_eshi << 8) | int'(b);
            if (e_cls != 0) begin
                is_mp3 = (e_cls == 1);
                if (aud_n < SLOTS) begin
                    aud_tab[aud_n] = e_pid[12:0];
                    aud_n++;
                end
            end
            nxt = cursor + 5 + es;
            cursor = nxt > 255 ? 255 : nxt;
        end
    endfunction

    // audio payload with pes header stripping
    function automatic void audio_in(int pos, logic [7:0] b);
        int p;
        int rel;
        int ds;
        bit last;
        p = adapt ? 5 + alen : 4;
        last = (pos == PKT_LEN - 1);
        if (pos < p) return;
        rel = pos - p;
        if (rel == 0) begin
            look0 = b;
            if (last) put_word(b);
        end else if (rel == 1) begin
            look1 = b;
            if (last) begin
                put_word(look0);
                put_word(b);
            end
        end else if (rel == 2) begin
            if (look0 == 8'h00 && look1 == 8'h00 && b == 8'h01) begin
                pes_start = int'(PES_PENDING);
            end else begin
                put_word(look0);
                put_word(look1);
                put_word(b);
                pes_start = p;
            end
        end else begin
            if (rel == 8 && pes_start == int'(PES_PENDING)) begin
                ds = p + 9 + int'(b);
                pes_start = ds > 511 ? 511 : ds;
                return;
            end
            if (pos >= pes_start) put_word(b);
        end
    endfunction

    function automatic void demux_byte(logic [7:0] b);
        int pos;
        int base;
        burst.delete();
        if (!in_pkt) begin
            if (b == SYNC_BYTE) begin
                in_pkt = 1;
                pkt_pos = 1;
                clear_pkt();
            end
            return;
        end
        pos = pkt_pos;
        if (pos == 1) begin
            pid = {b[4:0], 8'h00};
            ustart = b[6];
        end else if (pos == 2) begin
            pid[7:0] = b;
            if (pid == 0) kind = KIND_PAT;
            else if (aud_n > 0) kind = pid_listed(1, pid) ? KIND_AUDIO : KIND_IGNORE;
            else if (pmt_n > 0 && pid_listed(0, pid)) kind = KIND_PMT;
            else kind = KIND_IGNORE;
        end else if (pos == 3) begin
            adapt = b[5];
        end
        if (pos == 4 && adapt) alen = int'(b);
        if (pos >= 4) begin
            base = ustart ? 5 : 4;
            if (kind == KIND_PAT && pos >= base) pat_in(pos - base, b);
            else if (kind == KIND_PMT && pos >= base) pmt_in(pos - base, b);
            else if (kind == KIND_AUDIO && !(pos == 4 && adapt)) audio_in(pos, b);
        end
        if (pos >= PKT_LEN - 1) begin
            in_pkt = 0;
            pkt_pos = 0;
        end else begin
            pkt_pos = pos + 1;
        end
        if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
        foreach (burst[i]) audio_expect.push_back(burst[i]);
    endfunction

    // predict on accepted input, compare on accepted output
    always @(posedge i_clk) begin
        t_word exp_w;
        if (!i_rst_n) begin
            pkt_pos = 0;
            in_pkt = 0;
            pmt_n = 0;
            aud_n = 0;
            is_mp3 = 0;
            clear_pkt();
            audio_expect.delete();
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) demux_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (audio_expect.size() == 0) begin
                    $display("%0t: unexpected word, actual %h/%b/%b", $time,
                             i_out_data.audio_byte, i_out_data.format_mp3,
                             i_out_data.run_last);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = audio_expect.pop_front();
                    if (exp_w !== i_out_data) begin
                        $display("%0t: mismatch, expected %h/%b/%b actual %h/%b/%b",
                                 $time, exp_w.audio_byte, exp_w.format_mp3,
                                 exp_w.run_last, i_out_data.audio_byte,
                                 i_out_data.format_mp3, i_out_data.run_last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= audio_expect.size();
    end
endmodule

@@ sim/ts_audio_demux_unit_tb.sv @@
`timescale 1ns / 1ps
// ts_audio_demux_unit_tb: drives transport stream packets into the demux under
// several idle and stall patterns; checking lives in tsad_checker
// depends on tsad_pkg, tsad_if, ts_audio_demux_unit, tsad_checker
module ts_audio_demux_unit_tb;
    import tsad_pkg::*;

    localparam int PKT_LEN   = 188;
    localparam int MAX_CYCLE = 200000;
    localparam int HOLD_LEN  = 400;
    localparam int AUDIO_LEN = 94;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_go = 0;
    logic hold_on = 1'b0;

    logic [7:0] pkt [PKT_LEN];
    int         pbase;
    int         pcur;

    tsad_if #(.W(8))  in_if (i_clk);
    tsad_if #(.W(10)) out_if (i_clk);

    ts_audio_demux_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    tsad_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .i_in_ready  (in_if.ready),
        .i_in_data   (in_if.data),
        .i_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_out_data  (t_word'(out_if.data)),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        out_if.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
    end

    // long hold-off, counted here
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // bytes lo up to hi-1 of the packet buffer
    task automatic send_range(input int lo, input int hi);
        for (int i = lo; i < hi; i++) send_byte(pkt[i]);
    endtask

    task automatic send_packet(input int n);
        send_range(0, n);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // sync, random flag bits, pid, adaptation control, random body
    task automatic fill_header(input logic [12:0] p, input bit us, input bit ad);
        logic [1:0] r2;
        logic [3:0] r4;
        for (int i = 1; i < PKT_LEN; i++) pkt[i] = 8'($urandom);
        r2 = 2'($urandom);
        r4 = 4'($urandom);
        pkt[0] = SYNC_BYTE;
        pkt[1] = {r2[1], us, r2[0], p[12:8]};
        pkt[2] = p[7:0];
        pkt[3] = {r4[3:2], ad ? 2'b11 : 2'b01, r4};
        r2 = 2'($urandom);
        pkt[3][7:6] = r2;
    endtask

    task automatic pat_packet(input logic [12:0] pids [$], input int sl);
        fill_header(13'h0, 1'b1, 1'b0);
        pkt[4] = 8'h00;
        pkt[5] = 8'h00;
        pkt[6] = {4'hB, 4'(sl >> 8)};
        pkt[7] = 8'(sl);
        foreach (pids[k]) begin
            pkt[5 + 8 + 4 * k + 2] = {3'b111, pids[k][12:8]};
            pkt[5 + 8 + 4 * k + 3] = pids[k][7:0];
        end
        send_packet(PKT_LEN);
    endtask

    task automatic pmt_start(input logic [12:0] p, input bit us, input int pil);
        fill_header(p, us, 1'b0);
        pbase = us ? 5 : 4;
        if (us) pkt[4] = 8'h00;
        pkt[pbase]      = 8'h02;
        pkt[pbase + 10] = {4'hF, 4'(pil >> 8)};
        pkt[pbase + 11] = 8'(pil);
        pcur = 12 + pil;
    endtask

    task automatic set_section(input int sl);
        pkt[pbase + 1] = {4'hB, 4'(sl >> 8)};
        pkt[pbase + 2] = 8'(sl);
    endtask

    // one stream entry at the cursor, cut off at the packet end
    task automatic put_entry(input logic [7:0] st, input logic [12:0] ep, input int es);
        logic [7:0] eb [5];
        eb = '{st, {3'b111, ep[12:8]}, ep[7:0], {4'hF, 4'(es >> 8)}, 8'(es)};
        for (int k = 0; k < 5; k++)
            if (pbase + pcur + k < PKT_LEN) pkt[pbase + pcur + k] = eb[k];
        pcur += 5 + es;
    endtask

    // adl < 0: no adaptation field; pes < 0: no start code
    task automatic audio_fill(input logic [12:0] p, input int adl, input int pes);
        int pl;
        fill_header(p, 1'($urandom), adl >= 0);
        if (adl >= 0) pkt[4] = 8'(adl);
        pl = adl >= 0 ? 5 + adl : 4;
        if (pes >= 0 && pl + 8 < PKT_LEN) begin
            pkt[pl] = 8'h00;
            pkt[pl + 1] = 8'h00;
            pkt[pl + 2] = 8'h01;
            pkt[pl + 8] = 8'(pes);
        end
    endtask

    initial begin
        logic [12:0] pat_list [$];
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise before any sync, field extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h46);
        // pat: duplicate pid, full list, entry past the crc dropped
        pat_list = '{13'h100, 13'h100, 13'h101, 13'h1FFE, 13'h102, 13'h103};
        pat_packet(pat_list, 32);
        // pmt with the sender mostly idle: all audio types, duplicate, video,
        // overflow of the audio list
        idle_pct = 86;
        pmt_start(13'h1FFE, 1'b1, 2);
        put_entry(ST_AAC_A, 13'h200, 0);
        put_entry(ST_MP3, 13'h201, 2);
        put_entry(ST_AAC_B, 13'h200, 0);
        put_entry(8'h1B, 13'h300, 0);
        put_entry(ST_AAC_A, 13'h202, 0);
        put_entry(ST_MP3, 13'h203, 0);
        set_section(pcur + 1);
        send_packet(PKT_LEN);

        // audio packet with a pes header, spread over the stall phases
        audio_fill(13'h201, -1, 3);
        idle_pct  = 0;
        stall_pct = 86;
        send_range(0, 30);
        idle_pct  = 36;
        stall_pct = 36;
        send_range(30, 50);

        // receiver holds off while the sender keeps going
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1;
        send_range(50, 70);
        // sender waits for every word, then the rest of the packet
        drain();
        send_range(70, AUDIO_LEN);

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ ts_audio_demux_unit.f @@
rtl/tsad_pkg.sv
rtl/tsad_if.sv
rtl/tsad_parse.sv
rtl/tsad_outq.sv
rtl/ts_audio_demux_unit.sv
sim/tsad_checker.sv
sim/ts_audio_demux_unit_tb.sv
